[sv/fst_pkg.sv]
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types and constants for the frame sequence timer.
// ----------------------------------------------------------------------------
`default_nettype none

package fst_pkg;

  localparam int MAX_FRAMES_DEF = 32;
  localparam int TIME_BITS_DEF  = 16;

  // Stream payload widths
  localparam int IN_TUSER_W  = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // Result field widths
  localparam int FRAME_IDX_W = 5;
  localparam int LOADED_W    = 6;

  // Result tdata bit positions
  localparam int OUT_IDX_LSB     = 0;
  localparam int OUT_PLAYING_BIT = 5;
  localparam int OUT_FINISH_BIT  = 6;
  localparam int OUT_LOADED_LSB  = 7;
  localparam int OUT_DROP_BIT    = 13;

  typedef enum logic [IN_TUSER_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_PLAY    = 3'd3,
    CMD_PAUSE   = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_RESTART = 3'd6
  } fst_cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_ADV  = 1'b1
  } fst_state_t;

endpackage

`default_nettype wire

[sv/frame_sequence_timer_core.sv]
// ----------------------------------------------------------------------------
// frame_sequence_timer_core
// Sprite frame sequencer: duration table in RAM, timer, play/finish flags.
// ----------------------------------------------------------------------------
// Every command transaction returns one status transaction. Add, clear, play,
// pause, stop, restart, an unused code and a tick that has nothing to do
// finish in the accept cycle. A tick that runs stays in the advance state
// until its time no longer covers the current frame's duration or it ends
// a one-shot run: each cycle compares the timer with one duration read
// from the table RAM, and the RAM's registered read is overlapped
// by addressing it with the next frame index. A new command is taken only
// when the sequencer is idle and the status register is empty or being
// drained. Durations below one unit are stored as one; an add to a full
// table is dropped and flagged in the status. loop_enable may be written
// between commands and selects wrap versus hold-last-and-finish.
`default_nettype none

module frame_sequence_timer_core #(
  parameter int MAX_FRAMES = fst_pkg::MAX_FRAMES_DEF,
  parameter int TIME_BITS  = fst_pkg::TIME_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // config
  input  wire                                 cfg_wr_en,
  input  wire                                 cfg_wr_data,   // loop_enable
  // command stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [fst_pkg::IN_TDATA_W-1:0]      in_tdata,      // [15:0] time_value
  input  wire  [fst_pkg::IN_TUSER_W-1:0]      in_tuser,      // [2:0] cmd
  // status stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [4:0] frame_index, [5] is_playing, [6] is_finished,
  // [12:7] frames_loaded, [13] add_dropped, [15:14] zero
  output logic [fst_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import fst_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int TMR_W = TIME_BITS + 1;

  fst_state_t state_r, state_nxt;

  logic [IDX_W-1:0]     cur_idx_r, cur_idx_nxt;
  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [TMR_W-1:0]     timer_r, timer_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic                 loop_en_r;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Duration table RAM
  logic [TIME_BITS-1:0] dur_mem [MAX_FRAMES];
  logic [TIME_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [TIME_BITS-1:0] wr_data;

  logic                 in_acc;
  fst_cmd_t             cmd;
  logic [47:0]          tv_ext;
  logic [TIME_BITS-1:0] delta;
  logic [TIME_BITS-1:0] dur;
  logic [CNT_W-1:0]     idx_plus1;
  logic                 res_load;
  logic                 dropped;
  logic [31:0]          idx_ext;
  logic [31:0]          total_ext;

  assign in_acc = in_tvalid && in_tready;
  assign cmd    = fst_cmd_t'(in_tuser);
  assign tv_ext = 48'(in_tdata);
  assign delta  = tv_ext[TIME_BITS-1:0];
  assign wr_data = (delta == '0) ? TIME_BITS'(1) : delta;
  assign dur    = (rd_data_r == '0) ? TIME_BITS'(1) : rd_data_r;
  assign idx_plus1 = CNT_W'(cur_idx_r) + CNT_W'(1);
  assign rd_addr   = cur_idx_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dur_mem[total_r[IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= dur_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_idx_r    <= '0;
      total_r      <= '0;
      timer_r      <= '0;
      run_r        <= 1'b0;
      done_r       <= 1'b0;
      loop_en_r    <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_idx_r    <= cur_idx_nxt;
      total_r      <= total_nxt;
      timer_r      <= timer_nxt;
      run_r        <= run_nxt;
      done_r       <= done_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        loop_en_r <= cfg_wr_data;
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cur_idx_nxt = cur_idx_r;
    total_nxt   = total_r;
    timer_nxt   = timer_r;
    run_nxt     = run_r;
    done_nxt    = done_r;
    wr_en       = 1'b0;
    res_load    = 1'b0;
    dropped     = 1'b0;
    in_tready   = (state_r == ST_IDLE) && (!out_tvalid_r || out_tready);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_load = 1'b1;
          unique case (cmd)
            CMD_TICK: begin
              if (run_r && !done_r && (total_r >= CNT_W'(2))) begin
                timer_nxt = timer_r + TMR_W'(delta);
                state_nxt = ST_ADV;
                res_load  = 1'b0;
              end
            end
            CMD_ADD: begin
              if (total_r == CNT_W'(MAX_FRAMES)) begin
                dropped = 1'b1;
              end else begin
                wr_en     = 1'b1;
                total_nxt = total_r + CNT_W'(1);
              end
            end
            CMD_CLEAR: begin
              total_nxt   = '0;
              cur_idx_nxt = '0;
              timer_nxt   = '0;
              run_nxt     = 1'b0;
              done_nxt    = 1'b0;
            end
            CMD_PLAY: begin
              if (done_r) begin
                cur_idx_nxt = '0;
                timer_nxt   = '0;
                done_nxt    = 1'b0;
              end
              run_nxt = 1'b1;
            end
            CMD_PAUSE: begin
              run_nxt = 1'b0;
            end
            CMD_STOP: begin
              run_nxt     = 1'b0;
              done_nxt    = 1'b0;
              cur_idx_nxt = '0;
              timer_nxt   = '0;
            end
            CMD_RESTART: begin
              cur_idx_nxt = '0;
              timer_nxt   = '0;
              done_nxt    = 1'b0;
              run_nxt     = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADV: begin
        // rd_data_r holds the duration of cur_idx_r
        if (timer_r < TMR_W'(dur)) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          timer_nxt = timer_r - TMR_W'(dur);
          if (idx_plus1 < total_r) begin
            cur_idx_nxt = idx_plus1[IDX_W-1:0];
          end else if (loop_en_r) begin
            cur_idx_nxt = '0;
          end else begin
            done_nxt  = 1'b1;
            run_nxt   = 1'b0;
            timer_nxt = '0;
            res_load  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // status register is known empty whenever a result is loaded
    out_tvalid_nxt = res_load ? 1'b1 : (out_tvalid_r && !out_tready);
  end

  assign idx_ext   = 32'(cur_idx_nxt);
  assign total_ext = 32'(total_nxt);

  always_comb begin
    out_tdata_nxt = '0;
    out_tdata_nxt[OUT_IDX_LSB +: FRAME_IDX_W] = idx_ext[FRAME_IDX_W-1:0];
    out_tdata_nxt[OUT_PLAYING_BIT]            = run_nxt;
    out_tdata_nxt[OUT_FINISH_BIT]             = done_nxt;
    out_tdata_nxt[OUT_LOADED_LSB +: LOADED_W] = total_ext[LOADED_W-1:0];
    out_tdata_nxt[OUT_DROP_BIT]               = dropped;
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

[sv/fst_checker.sv]
// ----------------------------------------------------------------------------
// fst_checker
// Port-level checks for the frame sequence timer, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module fst_checker #(
  parameter int MAX_FRAMES = fst_pkg::MAX_FRAMES_DEF
) (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [fst_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fst_pkg::*;

  localparam logic [LOADED_W-1:0] FULL_LOADED = LOADED_W'(MAX_FRAMES);

  // held status transaction must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("status changed while stalled");

  // no new command while an unread status sits in the output register
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("command taken while status stalled");

  // finished and playing never both set
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[OUT_PLAYING_BIT] && out_tdata[OUT_FINISH_BIT]))
    else $error("playing and finished both set");

  // a dropped add only happens on a full table
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DROP_BIT]
      |-> out_tdata[OUT_LOADED_LSB +: LOADED_W] == FULL_LOADED)
    else $error("add dropped with room in table");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("status valid after reset");

endmodule

bind frame_sequence_timer_core fst_checker #(
  .MAX_FRAMES (MAX_FRAMES)
) u_fst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[tb/frame_sequence_timer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_sequence_timer_checker
// Passive scoreboard for the frame sequence timer. It tracks loop_enable
// writes and every command transaction, and keeps its own copy of the
// duration table, frame index, timer and play/finish flags. From these it
// predicts one status per command and compares each status transaction,
// field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module frame_sequence_timer_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_wr_en,
  input  wire                             cfg_wr_data,
  input  wire                             in_tvalid,
  input  wire                             in_tready,
  input  wire [fst_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] time_value
  input  wire [fst_pkg::IN_TUSER_W-1:0]   in_tuser,   // [2:0] cmd
  input  wire                             out_tvalid,
  input  wire                             out_tready,
  // [4:0] frame_index, [5] is_playing, [6] is_finished,
  // [12:7] frames_loaded, [13] add_dropped, [15:14] zero
  input  wire [fst_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output int                              fail_count,
  output int                              pending
);
  import fst_pkg::*;

  typedef struct packed {
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   is_playing;
    logic                   is_finished;
    logic [LOADED_W-1:0]    frames_loaded;
    logic                   add_dropped;
  } status_t;

  logic [15:0]            dur_tbl [MAX_FRAMES_DEF];
  logic [LOADED_W-1:0]    loaded;
  logic [FRAME_IDX_W-1:0] idx;
  logic [16:0]            timer;
  logic                   playing;
  logic                   finished;
  logic                   loop_en;
  status_t                status_q [$];
  int                     errs = 0;

  task automatic advance_sequencer(input logic [2:0] cmd, input logic [15:0] tv,
                                   output status_t st);
    logic [15:0] cur;
    logic        stepping;
    st.add_dropped = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (playing && !finished && loaded >= 6'd2) begin
          timer = timer + {1'b0, tv};
          stepping = 1'b1;
          // walk frames while the timer covers the current duration
          while (stepping) begin
            cur = dur_tbl[idx];
            if (timer < {1'b0, cur}) begin
              stepping = 1'b0;
            end else begin
              timer = timer - {1'b0, cur};
              if (int'(idx) + 1 < int'(loaded)) begin
                idx = idx + 1'b1;
              end else if (loop_en) begin
                idx = '0;
              end else begin
                finished = 1'b1;
                playing  = 1'b0;
                timer    = '0;
                stepping = 1'b0;
              end
            end
          end
        end
      end
      CMD_ADD: begin
        if (int'(loaded) >= MAX_FRAMES_DEF) begin
          st.add_dropped = 1'b1;
        end else begin
          dur_tbl[loaded[4:0]] = (tv == 16'd0) ? 16'd1 : tv;
          loaded = loaded + 1'b1;
        end
      end
      CMD_CLEAR: begin
        loaded   = '0;
        idx      = '0;
        timer    = '0;
        playing  = 1'b0;
        finished = 1'b0;
      end
      CMD_PLAY: begin
        if (finished) begin
          idx      = '0;
          timer    = '0;
          finished = 1'b0;
        end
        playing = 1'b1;
      end
      CMD_PAUSE: playing = 1'b0;
      CMD_STOP: begin
        playing  = 1'b0;
        finished = 1'b0;
        idx      = '0;
        timer    = '0;
      end
      CMD_RESTART: begin
        idx      = '0;
        timer    = '0;
        finished = 1'b0;
        playing  = 1'b1;
      end
      default: ;
    endcase
    st.frame_index   = idx;
    st.is_playing    = playing;
    st.is_finished   = finished;
    st.frames_loaded = loaded;
  endtask

  always @(posedge clk) begin : watch
    status_t                want;
    logic [FRAME_IDX_W-1:0] got_idx;
    logic [LOADED_W-1:0]    got_loaded;
    logic                   got_playing;
    logic                   got_finished;
    logic                   got_dropped;
    logic [1:0]             got_pad;
    if (!rst_n) begin
      loaded   = '0;
      idx      = '0;
      timer    = '0;
      playing  = 1'b0;
      finished = 1'b0;
      loop_en  = 1'b1;
      status_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $error("status transaction with none expected: tdata 0x%h", out_tdata);
          errs++;
        end else begin
          want         = status_q.pop_front();
          got_idx      = out_tdata[OUT_IDX_LSB +: FRAME_IDX_W];
          got_playing  = out_tdata[OUT_PLAYING_BIT];
          got_finished = out_tdata[OUT_FINISH_BIT];
          got_loaded   = out_tdata[OUT_LOADED_LSB +: LOADED_W];
          got_dropped  = out_tdata[OUT_DROP_BIT];
          got_pad      = out_tdata[15:14];
          if (got_idx !== want.frame_index) begin
            $error("frame_index: expected %0d, got %0d", want.frame_index, got_idx);
            errs++;
          end
          if (got_playing !== want.is_playing) begin
            $error("is_playing: expected %0d, got %0d", want.is_playing, got_playing);
            errs++;
          end
          if (got_finished !== want.is_finished) begin
            $error("is_finished: expected %0d, got %0d", want.is_finished, got_finished);
            errs++;
          end
          if (got_loaded !== want.frames_loaded) begin
            $error("frames_loaded: expected %0d, got %0d", want.frames_loaded, got_loaded);
            errs++;
          end
          if (got_dropped !== want.add_dropped) begin
            $error("add_dropped: expected %0d, got %0d", want.add_dropped, got_dropped);
            errs++;
          end
          if (got_pad !== 2'b00) begin
            $error("pad: expected 0, got %0d", got_pad);
            errs++;
          end
        end
      end
      // config writes are only to be made while the block is idle; the block does not enforce it
      if (cfg_wr_en) loop_en = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        advance_sequencer(in_tuser, in_tdata, want);
        status_q = {status_q, want};
      end
    end
    pending    <= status_q.size();
    fail_count <= errs;
  end

endmodule

[tb/frame_sequence_timer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_sequence_timer_core_test
// Stimulus for the frame sequence timer: a short directed run through every
// command and corner, then random animation clips (clear, adds, play, ticks
// mixed with transport commands) plus noise, over alternating loop_enable
// settings, with bursty input, random output stalls and long output holds.
// ----------------------------------------------------------------------------
module frame_sequence_timer_core_test;
  import fst_pkg::*;

  localparam logic [2:0] CMD_UNUSED     = 3'd7;
  localparam int         WATCHDOG_LIMIT = 1000000;
  localparam int         LONG_HOLD      = 400;
  localparam int         PHASE_ITEMS    = 500;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;   // [15:0] time_value
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;   // [2:0] cmd
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // [4:0] frame_index, [5] is_playing, [6] is_finished,
  // [12:7] frames_loaded, [13] add_dropped, [15:14] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     fail_count;
  int                     pending;
  int                     burst_left  = 0;
  int                     sent_count  = 0;
  int                     idle_cycles = 0;
  bit                     hold_req    = 1'b0;

  always #5 clk = ~clk;

  frame_sequence_timer_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  frame_sequence_timer_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // one command transaction; sender runs in bursts with random gaps
  task automatic issue(input logic [2:0] cmd, input logic [15:0] tv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= tv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_status();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_loop(input logic val);
    drain_status();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] pick_duration();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return 16'd0;
      1:       return 16'($urandom);
      2:       return 16'($urandom_range(100, 2000));
      default: return 16'($urandom_range(1, 12));
    endcase
  endfunction

  // large deltas are rare: a tick walks one frame per cycle
  function automatic logic [15:0] pick_delta();
    int r;
    r = $urandom_range(0, 199);
    if (r == 0) return 16'($urandom);
    if (r <= 12) return 16'($urandom_range(0, 1023));
    return 16'($urandom_range(0, 30));
  endfunction

  task automatic play_random_clip();
    int n_add;
    int r;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) issue(3'($urandom_range(0, 7)), 16'($urandom));
    end else begin
      if ($urandom_range(0, 4) != 0) issue(CMD_CLEAR, 16'($urandom));
      r = $urandom_range(0, 15);
      if (r == 0) n_add = $urandom_range(0, 1);
      else if (r < 3) n_add = $urandom_range(28, 36);   // runs into a full table
      else n_add = $urandom_range(2, 8);
      repeat (n_add) issue(CMD_ADD, pick_duration());
      issue($urandom_range(0, 1) ? CMD_PLAY : CMD_RESTART, 16'($urandom));
      repeat ($urandom_range(4, 24)) begin
        r = $urandom_range(0, 19);
        case (r)
          0:       issue(CMD_PAUSE, 16'($urandom));
          1:       issue(CMD_PLAY, 16'($urandom));
          2:       issue(CMD_STOP, 16'($urandom));
          3:       issue(CMD_RESTART, 16'($urandom));
          4:       issue(CMD_ADD, pick_duration());
          5:       issue(CMD_UNUSED, 16'($urandom));
          default: issue(CMD_TICK, pick_delta());
        endcase
      end
    end
  endtask

  // receiver: random stall pattern, plus a long hold when requested
  initial begin : receiver
    int mode;
    int span;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** frame_sequence_timer_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int target;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, few frames, clamp, wrap, pause, unused code
    issue(CMD_TICK, 16'd0);
    issue(CMD_PLAY, 16'd0);
    issue(CMD_TICK, 16'd5);
    issue(CMD_ADD, 16'd0);
    issue(CMD_ADD, 16'hFFFF);
    issue(CMD_ADD, 16'd3);
    issue(CMD_TICK, 16'hFFFF);
    issue(CMD_TICK, 16'd4);
    issue(CMD_PAUSE, 16'h5555);
    issue(CMD_TICK, 16'd7);
    issue(CMD_UNUSED, 16'hAAAA);
    issue(CMD_RESTART, 16'd0);
    issue(CMD_STOP, 16'd0);
    issue(CMD_CLEAR, 16'd0);

    // one-shot: finish, ignored tick, play after finish
    set_loop(1'b0);
    issue(CMD_ADD, 16'd2);
    issue(CMD_ADD, 16'd1);
    issue(CMD_PLAY, 16'd0);
    issue(CMD_TICK, 16'd10);
    issue(CMD_TICK, 16'd3);
    issue(CMD_PLAY, 16'd0);
    issue(CMD_TICK, 16'd2);
    issue(CMD_RESTART, 16'hFFFF);

    for (phase = 0; phase < 4; phase++) begin
      set_loop(phase % 2 == 0);
      if (phase % 2 == 0) hold_req = 1'b1;
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) play_random_clip();
    end

    drain_status();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** frame_sequence_timer_core: PASSED **");
    end else begin
      $display("** frame_sequence_timer_core: FAILED **");
    end
    $finish;
  end

endmodule
